// ===== sv/blid_pkg.sv =====
// Shared constants, types and slot arithmetic for the bounded list unit.
package blid_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CNT_W:0] sum_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_DELETE     = 2'd2,
    OP_NOP        = 2'd3
  } op_t;

  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    data_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } ram_req_t;

  function automatic idx_t slot(input idx_t front, input cnt_t off);
    sum_t s;
    s = sum_t'(front) + sum_t'(off);
    if (s >= sum_t'(DEPTH)) begin
      s = s - sum_t'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic idx_t idx_dec(input idx_t front);
    idx_t r;
    if (front == '0) begin
      r = idx_t'(DEPTH - 1);
    end else begin
      r = front - idx_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/bounded_list_insert_delete_dump_unit.sv =====
// Bounded double-ended list with positional delete and full listing after each item.
// Takes one item at a time: in_ready is high only between listings. After acceptance, a
// delete at position p of a list of n elements closes the gap through the element store,
// and skips this when p is n-1. The list is then read out front to back: a first read is
// issued, then each element is loaded and then output, since the store has a single
// registered read port. An empty list gives its single result in the cycle after
// acceptance. Inserts into a full list leave the list as it is and set
// out_insert_dropped on every result of that listing.
module bounded_list_insert_delete_dump_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_operand_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_element_value,
  output logic               out_last_of_listing,
  output logic               out_list_empty,
  output logic               out_insert_dropped
);
  import blid_pkg::*;

  ram_req_t ram_req;
  data_t    rd_data;

  blid_seq u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_operand_value    (in_operand_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_element_value   (out_element_value),
    .out_last_of_listing (out_last_of_listing),
    .out_list_empty      (out_list_empty),
    .out_insert_dropped  (out_insert_dropped),
    .ram_req             (ram_req),
    .rd_data             (rd_data)
  );

  blid_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

endmodule

// ===== sv/blid_ram.sv =====
// Element store: one write port, one registered read port.
module blid_ram (
  input  logic              clk,
  input  blid_pkg::ram_req_t req,
  output blid_pkg::data_t   rd_data
);
  import blid_pkg::*;

  data_t mem [DEPTH];
  data_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/blid_seq.sv =====
// Sequencer: applies each operation to the store, closes gaps and lists the elements.
module blid_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_opcode,
  input  logic signed [31:0]     in_operand_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     out_element_value,
  output logic                   out_last_of_listing,
  output logic                   out_list_empty,
  output logic                   out_insert_dropped,
  output blid_pkg::ram_req_t     ram_req,
  input  blid_pkg::data_t        rd_data
);
  import blid_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_RD    = 5'b00100,
    S_LD    = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  idx_t   front_r, front_nxt;
  cnt_t   count_r, count_nxt;
  cnt_t   idx_r, idx_nxt;
  cnt_t   shift_rd_r, shift_rd_nxt;
  cnt_t   wr_off_r, wr_off_nxt;
  logic   wr_pend_r, wr_pend_nxt;
  logic   dropped_r, dropped_nxt;
  data_t  elem_r, elem_nxt;
  logic   last_r, last_nxt;
  logic   empty_r, empty_nxt;

  always_comb begin
    cnt_t pos_v;
    logic shift_v;
    state_nxt    = state_r;
    front_nxt    = front_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    shift_rd_nxt = shift_rd_r;
    wr_off_nxt   = wr_off_r;
    wr_pend_nxt  = wr_pend_r;
    dropped_nxt  = dropped_r;
    elem_nxt     = elem_r;
    last_nxt     = last_r;
    empty_nxt    = empty_r;
    ram_req      = '0;
    pos_v        = in_operand_value[CNT_W-1:0];
    shift_v      = 1'b0;
    in_ready     = (state_r == S_IDLE);
    out_valid    = (state_r == S_OUT);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dropped_nxt = 1'b0;
          unique case (op_t'(in_opcode))
            OP_PUSH_FRONT: begin
              if (count_r == cnt_t'(DEPTH)) begin
                dropped_nxt = 1'b1;
              end else begin
                front_nxt       = idx_dec(front_r);
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_dec(front_r);
                ram_req.wr_data = in_operand_value;
                count_nxt       = count_r + cnt_t'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (count_r == cnt_t'(DEPTH)) begin
                dropped_nxt = 1'b1;
              end else begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = slot(front_r, count_r);
                ram_req.wr_data = in_operand_value;
                count_nxt       = count_r + cnt_t'(1);
              end
            end
            OP_DELETE: begin
              if (!in_operand_value[31] &&
                  $unsigned(in_operand_value) < 32'(count_r)) begin
                if (pos_v + cnt_t'(1) < count_r) begin
                  shift_v      = 1'b1;
                  shift_rd_nxt = pos_v + cnt_t'(1);
                  wr_pend_nxt  = 1'b0;
                end else begin
                  count_nxt = count_r - cnt_t'(1);
                end
              end
            end
            default: begin
            end
          endcase
          idx_nxt = '0;
          if (shift_v) begin
            state_nxt = S_SHIFT;
          end else if (count_nxt == '0) begin
            elem_nxt  = '0;
            last_nxt  = 1'b1;
            empty_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_SHIFT: begin
        ram_req.wr_en   = wr_pend_r;
        ram_req.wr_addr = slot(front_r, wr_off_r);
        ram_req.wr_data = rd_data;
        if (shift_rd_r < count_r) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = slot(front_r, shift_rd_r);
          wr_pend_nxt     = 1'b1;
          wr_off_nxt      = shift_rd_r - cnt_t'(1);
          shift_rd_nxt    = shift_rd_r + cnt_t'(1);
        end else begin
          wr_pend_nxt = 1'b0;
          count_nxt   = count_r - cnt_t'(1);
          idx_nxt     = '0;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = slot(front_r, idx_r);
        state_nxt       = S_LD;
      end
      S_LD: begin
        elem_nxt  = rd_data;
        last_nxt  = (idx_r + cnt_t'(1) == count_r);
        empty_nxt = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt         = idx_r + cnt_t'(1);
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = slot(front_r, idx_r + cnt_t'(1));
            state_nxt       = S_LD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      count_r   <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    shift_rd_r <= shift_rd_nxt;
    wr_off_r   <= wr_off_nxt;
    dropped_r  <= dropped_nxt;
    elem_r     <= elem_nxt;
    last_r     <= last_nxt;
    empty_r    <= empty_nxt;
  end

  assign out_element_value   = elem_r;
  assign out_last_of_listing = last_r;
  assign out_list_empty      = empty_r;
  assign out_insert_dropped  = dropped_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("element count exceeds depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while a listing is open");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_list_empty) |-> (out_last_of_listing && out_element_value == '0))
    else $error("empty listing not a single final zero result");

  a_rw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
    else $error("read and write hit the same entry");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_of_listing) |=> in_ready)
    else $error("not ready after final transfer of a listing");
`endif

endmodule

// ===== verif/tb_bounded_list_insert_delete_dump_unit.sv =====
// Self-checking testbench for the bounded list unit: directed table, then random traffic.
module tb_bounded_list_insert_delete_dump_unit;
  import blid_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int CHUNK_ITEMS = 20;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        empty;
    logic        dropped;
  } listing_beat_t;

  typedef struct {
    op_t           op;
    logic [31:0]   operand;
    int            reps;
    bit            typed;
    listing_beat_t beat;
  } stim_row_t;

  localparam listing_beat_t EMPTY_BEAT = '{32'h0, 1'b1, 1'b1, 1'b0};
  localparam listing_beat_t NO_BEAT = '0;

  stim_row_t dir_rows [16] = '{
    '{OP_NOP,        32'h0000_0000, 1,  1'b1, EMPTY_BEAT},
    '{OP_DELETE,     32'h0000_0000, 1,  1'b1, EMPTY_BEAT},
    '{OP_DELETE,     32'h8000_0000, 1,  1'b1, EMPTY_BEAT},
    '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1,  1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
    '{OP_DELETE,     32'h0000_0000, 1,  1'b1, EMPTY_BEAT},
    '{OP_PUSH_BACK,  32'h8000_0000, 1,  1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0}},
    '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1,  1'b0, NO_BEAT},
    '{OP_DELETE,     32'hFFFF_FFFF, 1,  1'b0, NO_BEAT},
    '{OP_DELETE,     32'h0000_0002, 1,  1'b0, NO_BEAT},
    '{OP_PUSH_BACK,  32'h5555_5555, 8,  1'b0, NO_BEAT},
    '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 6,  1'b0, NO_BEAT},
    '{OP_PUSH_FRONT, 32'h1234_5678, 1,  1'b0, NO_BEAT},
    '{OP_PUSH_BACK,  32'h8765_4321, 1,  1'b0, NO_BEAT},
    '{OP_DELETE,     32'h0000_000F, 1,  1'b0, NO_BEAT},
    '{OP_DELETE,     32'h0000_0007, 1,  1'b0, NO_BEAT},
    '{OP_DELETE,     32'h0000_0000, 1,  1'b0, NO_BEAT}
  };

  int sender_idle_by_phase [4] = '{0, 79, 0, 34};
  int receiver_stall_by_phase [4] = '{0, 0, 79, 34};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = '0;
  logic signed [31:0] in_operand_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_element_value;
  logic               out_last_of_listing;
  logic               out_list_empty;
  logic               out_insert_dropped;

  logic [31:0]   shadow_store [DEPTH];
  int unsigned   shadow_front = 0;
  int unsigned   shadow_count = 0;
  listing_beat_t pending_beats [$];
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  int            mismatches = 0;
  int            quiet_cycles = 0;

  bounded_list_insert_delete_dump_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_operand_value    (in_operand_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_element_value   (out_element_value),
    .out_last_of_listing (out_last_of_listing),
    .out_list_empty      (out_list_empty),
    .out_insert_dropped  (out_insert_dropped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic list_after_item(input op_t op, input logic [31:0] operand,
                                 output listing_beat_t listing [$]);
    bit            refused;
    int unsigned   pos;
    listing_beat_t beat;
    refused = 1'b0;
    listing = {};
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          refused = 1'b1;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_store[shadow_front] = operand;
          end else begin
            shadow_store[(shadow_front + shadow_count) % DEPTH] = operand;
          end
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (!operand[31] && operand < shadow_count) begin
          for (pos = operand; pos + 1 < shadow_count; pos++) begin
            shadow_store[(shadow_front + pos) % DEPTH] =
              shadow_store[(shadow_front + pos + 1) % DEPTH];
          end
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    if (shadow_count == 0) begin
      beat = '{32'h0, 1'b1, 1'b1, refused};
      listing.push_back(beat);
    end else begin
      for (pos = 0; pos < shadow_count; pos++) begin
        beat.value = shadow_store[(shadow_front + pos) % DEPTH];
        beat.last = (pos + 1 == shadow_count);
        beat.empty = 1'b0;
        beat.dropped = refused;
        listing.push_back(beat);
      end
    end
  endtask

  task automatic send_item(input op_t op, input logic [31:0] operand, input bit typed,
                           input listing_beat_t typed_beat);
    listing_beat_t listing [$];
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_operand_value <= operand;
    do @(posedge clk); while (!in_ready);
    list_after_item(op, operand, listing);
    if (typed) begin
      pending_beats.push_back(typed_beat);
    end else begin
      foreach (listing[k]) pending_beats.push_back(listing[k]);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin : result_check
    listing_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result: element_value %h last_of_listing %b",
               out_element_value, out_last_of_listing);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        if (out_element_value !== want.value) begin
          $error("element_value: expected %h, got %h", want.value, out_element_value);
          mismatches++;
        end
        if (out_last_of_listing !== want.last) begin
          $error("last_of_listing: expected %b, got %b", want.last, out_last_of_listing);
          mismatches++;
        end
        if (out_list_empty !== want.empty) begin
          $error("list_empty: expected %b, got %b", want.empty, out_list_empty);
          mismatches++;
        end
        if (out_insert_dropped !== want.dropped) begin
          $error("insert_dropped: expected %b, got %b", want.dropped, out_insert_dropped);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    op_t         op;
    logic [31:0] operand;
    bit          filling;
    int unsigned roll;
    filling = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        send_item(dir_rows[r].op, dir_rows[r].operand, dir_rows[r].typed, dir_rows[r].beat);
      end
    end
    hold_until_drained();

    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 4; c++) begin
        sender_idle_pct = (c == 2) ? 0 : sender_idle_by_phase[p];
        receiver_stall_pct = (c == 2) ? 0 : receiver_stall_by_phase[p];
        for (int k = 0; k < CHUNK_ITEMS; k++) begin
          if (shadow_count == DEPTH) begin
            if ($urandom_range(0, 2) == 0) filling = 1'b0;
          end else if (shadow_count == 0) begin
            filling = 1'b1;
          end else if ($urandom_range(0, 29) == 0) begin
            filling = !filling;
          end
          roll = $urandom_range(0, 99);
          operand = $urandom;
          if (roll < 8) begin
            op = op_t'($urandom_range(0, 3));
          end else if (roll < 14) begin
            op = OP_NOP;
          end else if ((roll < 80) == filling) begin
            if ($urandom_range(0, 1) != 0) begin
              op = OP_PUSH_FRONT;
            end else begin
              op = OP_PUSH_BACK;
            end
            if ($urandom_range(0, 9) == 0) begin
              case ($urandom_range(0, 3))
                0: operand = 32'h7FFF_FFFF;
                1: operand = 32'h8000_0000;
                2: operand = 32'h0000_0000;
                default: operand = 32'hFFFF_FFFF;
              endcase
            end
          end else begin
            op = OP_DELETE;
            if ($urandom_range(0, 7) != 0) operand = $urandom_range(0, shadow_count);
          end
          send_item(op, operand, 1'b0, NO_BEAT);
        end
      end
      hold_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/blid_pkg.sv
sv/blid_ram.sv
sv/blid_seq.sv
sv/bounded_list_insert_delete_dump_unit.sv
verif/tb_bounded_list_insert_delete_dump_unit.sv
